### design/tpc_pkg.sv
// Shared types and constants of the text pane cursor controller.
`timescale 1ns / 1ps
`default_nettype none

package tpc_pkg;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_PUT_AT = 2'd1,
    OP_SET    = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CMD_DRAW   = 2'd0,
    CMD_SCROLL = 2'd1,
    CMD_CLEAR  = 2'd2,
    CMD_REPORT = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    REG_ENABLE    = 2'd0,
    REG_PANE_COLS = 2'd1,
    REG_PANE_ROWS = 2'd2,
    REG_PANE_TOP  = 2'd3
  } reg_idx_t;

  localparam logic [7:0] CH_NEWLINE   = 8'd10;
  localparam logic [7:0] CH_RETURN    = 8'd13;
  localparam logic [7:0] CH_BACKSPACE = 8'd8;
  localparam logic [6:0] GLYPH_SPACE  = 7'd32;

  localparam logic [7:0] RESET_COLS = 8'd80;
  localparam logic [7:0] RESET_ROWS = 8'd25;
  localparam logic [7:0] RESET_TOP  = 8'd0;

  // Result slots in delivery order.
  localparam int SLOT_HEAD   = 0;  // scroll or clear ahead of any draw
  localparam int SLOT_DRAW   = 1;
  localparam int SLOT_POST   = 2;  // scroll after the draw or newline
  localparam int SLOT_REPORT = 3;
  localparam int NUM_SLOTS   = 4;

  typedef struct packed {
    logic       enable;
    logic [7:0] cols;
    logic [7:0] rows;
    logic [7:0] top;
  } cfg_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    cmd_t                 head_cmd;
    logic [6:0]           glyph;
    logic [7:0]           draw_col;
    logic [8:0]           draw_row;
    logic [7:0]           cur_col;
    logic [7:0]           cur_row;
  } res_t;

endpackage

`default_nettype wire

### design/text_pane_cursor_controller.sv
// Top level of the text pane cursor controller: registers, result buffer, ports.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Signals                                        Direction
// --------  ---------------------------------------------  ---------
// in        in_valid, in_stall, opcode, char_code,          request in
//           target_col, target_row
// out       out_valid, out_stall, command, glyph,           results out
//           cell_col, cell_row, last
// cfg       cfg_we, cfg_index, cfg_data                     writes in
//
// A request is registered in the input register, then its results (one to
// four) leave the result buffer one per cycle while out_stall is low, paced
// by the single-port drain. Reset (rst, synchronous) empties both registers,
// homes the cursor and loads the register defaults. A stalled output holds
// the buffer; the input register still takes one more request, then
// in_stall rises.

module text_pane_cursor_controller (
  input  logic       clk,
  input  logic       rst,
  // request channel
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] opcode,
  input  logic [7:0] char_code,
  input  logic [7:0] target_col,
  input  logic [7:0] target_row,
  // result channel
  output logic       out_valid,
  input  logic       out_stall,
  output logic [1:0] command,
  output logic [6:0] glyph,
  output logic [7:0] cell_col,
  output logic [8:0] cell_row,
  output logic       last,
  // configuration writes
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [7:0] cfg_data
);

  tpc_pkg::cfg_t cfg;
  logic [7:0]    cursor_col;
  logic [7:0]    cursor_row;

  // input register
  logic          in_full;
  tpc_pkg::op_t  in_op;
  logic [7:0]    in_char;
  logic [7:0]    in_tcol;
  logic [7:0]    in_trow;

  // result buffer
  tpc_pkg::res_t buf_res;
  tpc_pkg::res_t step_res;

  logic in_take;
  logic out_take;
  logic buf_free;
  logic buf_load;
  logic [tpc_pkg::NUM_SLOTS-1:0] slots_next;

  // Configuration writes; the user must do them only while the block is idle; the block does not enforce it.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.enable <= 1'b0;
      cfg.cols   <= tpc_pkg::RESET_COLS;
      cfg.rows   <= tpc_pkg::RESET_ROWS;
      cfg.top    <= tpc_pkg::RESET_TOP;
    end else if (cfg_we) begin
      unique case (tpc_pkg::reg_idx_t'(cfg_index))
        tpc_pkg::REG_ENABLE:    cfg.enable <= cfg_data[0];
        tpc_pkg::REG_PANE_COLS: cfg.cols   <= cfg_data;
        tpc_pkg::REG_PANE_ROWS: cfg.rows   <= cfg_data;
        tpc_pkg::REG_PANE_TOP:  cfg.top    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // Work out the request held in the input register.
  tpc_step u_step (
    .cfg        (cfg),
    .cursor_col (cursor_col),
    .cursor_row (cursor_row),
    .op         (in_op),
    .char_code  (in_char),
    .target_col (in_tcol),
    .target_row (in_trow),
    .res        (step_res)
  );

  // Buffer frees up when empty or when its final report is taken now.
  assign out_take = out_valid && !out_stall;
  assign buf_free = (buf_res.slots == '0) || (out_take && last);
  assign buf_load = in_full && buf_free;
  assign in_stall = in_full && !buf_load;
  assign in_take  = in_valid && !in_stall;

  // Drop the slot just delivered: clear the lowest set bit.
  assign slots_next = buf_res.slots
                    & (buf_res.slots - {{(tpc_pkg::NUM_SLOTS-1){1'b0}}, 1'b1});

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_take) begin
      in_full <= 1'b1;
    end else if (buf_load) begin
      in_full <= 1'b0;
    end
  end

  // Payload of the input register needs no reset.
  always_ff @(posedge clk) begin
    if (in_take) begin
      in_op   <= tpc_pkg::op_t'(opcode);
      in_char <= char_code;
      in_tcol <= target_col;
      in_trow <= target_row;
    end
  end

  // Cursor advances when the request moves into the result buffer.
  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
    end else if (buf_load) begin
      cursor_col <= step_res.cur_col;
      cursor_row <= step_res.cur_row;
    end
  end

  // Slot bits are reset; the buffer payload needs none.
  always_ff @(posedge clk) begin
    if (buf_load) begin
      buf_res.head_cmd <= step_res.head_cmd;
      buf_res.glyph    <= step_res.glyph;
      buf_res.draw_col <= step_res.draw_col;
      buf_res.draw_row <= step_res.draw_row;
      buf_res.cur_col  <= step_res.cur_col;
      buf_res.cur_row  <= step_res.cur_row;
    end
    if (rst) begin
      buf_res.slots <= '0;
    end else if (buf_load) begin
      buf_res.slots <= step_res.slots;
    end else if (out_take) begin
      buf_res.slots <= slots_next;
    end
  end

  // Present the earliest pending slot.
  assign out_valid = (buf_res.slots != '0);
  assign last      = (slots_next == '0);

  always_comb begin
    command  = tpc_pkg::CMD_REPORT;
    glyph    = 7'd0;
    cell_col = 8'd0;
    cell_row = 9'd0;
    priority if (buf_res.slots[tpc_pkg::SLOT_HEAD]) begin
      command = buf_res.head_cmd;
    end else if (buf_res.slots[tpc_pkg::SLOT_DRAW]) begin
      command  = tpc_pkg::CMD_DRAW;
      glyph    = buf_res.glyph;
      cell_col = buf_res.draw_col;
      cell_row = buf_res.draw_row;
    end else if (buf_res.slots[tpc_pkg::SLOT_POST]) begin
      command = tpc_pkg::CMD_SCROLL;
    end else begin
      command  = tpc_pkg::CMD_REPORT;
      cell_col = buf_res.cur_col;
      cell_row = {1'b0, buf_res.cur_row};
    end
  end

endmodule

`default_nettype wire

### design/tpc_step.sv
// One request worked out: result commands and the new cursor position.
`timescale 1ns / 1ps
`default_nettype none

module tpc_step (
  input  tpc_pkg::cfg_t cfg,
  input  logic [7:0]    cursor_col,
  input  logic [7:0]    cursor_row,
  input  tpc_pkg::op_t  op,
  input  logic [7:0]    char_code,
  input  logic [7:0]    target_col,
  input  logic [7:0]    target_row,
  output tpc_pkg::res_t res
);

  logic [7:0] col;
  logic [7:0] row;
  logic [7:0] bottom;
  logic [8:0] row_inc;
  logic [8:0] col_inc;
  logic [6:0] glyph_in;

  assign bottom   = (cfg.rows == 8'd0) ? 8'd0 : cfg.rows - 8'd1;
  assign glyph_in = char_code[7] ? 7'd0 : char_code[6:0];

  always_comb begin
    res          = '0;
    res.head_cmd = tpc_pkg::CMD_SCROLL;
    col          = cursor_col;
    row          = cursor_row;
    row_inc      = 9'd0;
    col_inc      = 9'd0;

    unique case (op)
      tpc_pkg::OP_PUT: begin
        if (cfg.enable) begin
          // Pull an out-of-range cursor back into the pane first.
          if (col >= cfg.cols && cfg.cols != 8'd0) begin
            col     = 8'd0;
            row_inc = {1'b0, row} + 9'd1;
            if (row_inc >= {1'b0, cfg.rows}) begin
              res.slots[tpc_pkg::SLOT_HEAD] = 1'b1;
              row = bottom;
            end else begin
              row = row_inc[7:0];
            end
          end
          if (row >= cfg.rows && cfg.rows != 8'd0) begin
            res.slots[tpc_pkg::SLOT_HEAD] = 1'b1;
            row = bottom;
          end

          priority if (char_code == tpc_pkg::CH_NEWLINE) begin
            col     = 8'd0;
            row_inc = {1'b0, row} + 9'd1;
            if (row_inc >= {1'b0, cfg.rows}) begin
              res.slots[tpc_pkg::SLOT_POST] = 1'b1;
              row = bottom;
            end else begin
              row = row_inc[7:0];
            end
          end else if (char_code == tpc_pkg::CH_RETURN) begin
            col = 8'd0;
          end else if (char_code == tpc_pkg::CH_BACKSPACE) begin
            if (col != 8'd0) begin
              col = col - 8'd1;
            end
            res.slots[tpc_pkg::SLOT_DRAW] = 1'b1;
            res.glyph    = tpc_pkg::GLYPH_SPACE;
            res.draw_col = col;
            res.draw_row = {1'b0, cfg.top} + {1'b0, row};
          end else begin
            res.slots[tpc_pkg::SLOT_DRAW] = 1'b1;
            res.glyph    = glyph_in;
            res.draw_col = col;
            res.draw_row = {1'b0, cfg.top} + {1'b0, row};
            col_inc      = {1'b0, col} + 9'd1;
            if (col_inc >= {1'b0, cfg.cols}) begin
              col     = 8'd0;
              row_inc = {1'b0, row} + 9'd1;
              if (row_inc >= {1'b0, cfg.rows}) begin
                res.slots[tpc_pkg::SLOT_POST] = 1'b1;
                row = bottom;
              end else begin
                row = row_inc[7:0];
              end
            end else begin
              col = col_inc[7:0];
            end
          end
        end
      end
      tpc_pkg::OP_PUT_AT: begin
        if (cfg.enable && target_col < cfg.cols && target_row < cfg.rows) begin
          res.slots[tpc_pkg::SLOT_DRAW] = 1'b1;
          res.glyph    = glyph_in;
          res.draw_col = target_col;
          res.draw_row = {1'b0, cfg.top} + {1'b0, target_row};
        end
      end
      tpc_pkg::OP_SET: begin
        if (target_col < cfg.cols) begin
          col = target_col;
        end
        if (target_row < cfg.rows) begin
          row = target_row;
        end
      end
      tpc_pkg::OP_CLEAR: begin
        col = 8'd0;
        row = 8'd0;
        if (cfg.enable) begin
          res.slots[tpc_pkg::SLOT_HEAD] = 1'b1;
          res.head_cmd = tpc_pkg::CMD_CLEAR;
        end
      end
      default: begin
      end
    endcase

    res.slots[tpc_pkg::SLOT_REPORT] = 1'b1;
    res.cur_col = col;
    res.cur_row = row;
  end

endmodule

`default_nettype wire
